>>> sv/mcf_pkg.sv
// ----------------------------------------------------------------------------
// mcf_pkg
// Shared types, codes and tables of the magic word command framer.
// ----------------------------------------------------------------------------
package mcf_pkg;

  localparam int NUM_WORDS = 21;

  localparam logic [31:0] MAGIC_WORDS [NUM_WORDS] = '{
    32'h41424344, 32'h45464748, 32'h0D15EA5E, 32'h99998888, 32'h99999999,
    32'h77776666, 32'h77777777, 32'h55551111, 32'h55661111, 32'h55552222,
    32'h55662222, 32'h66663333, 32'h66773333, 32'h66664444, 32'h66774444,
    32'h66665555, 32'h66775555, 32'h77771111, 32'h77881111, 32'h77772222,
    32'h77882222
  };

  // Operations
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Events
  localparam logic [2:0] EV_CMD      = 3'd0;
  localparam logic [2:0] EV_PAYLOAD  = 3'd1;
  localparam logic [2:0] EV_SETTINGS = 3'd2;
  localparam logic [2:0] EV_MFC      = 3'd3;
  localparam logic [2:0] EV_TIMEOUT  = 3'd4;

  // Collection modes
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_SET  = 2'd1;
  localparam logic [1:0] MODE_AIR  = 2'd2;
  localparam logic [1:0] MODE_O2   = 2'd3;

  // Commands that start collection
  localparam logic [4:0] CMD_NEW_SETTINGS = 5'd0;
  localparam logic [4:0] CMD_MFC_AIR_SET  = 5'd17;
  localparam logic [4:0] CMD_MFC_O2_SET   = 5'd19;

  // Command without payload
  localparam logic [4:0] CMD_REQUEST_SETTINGS = 5'd1;

  // Configuration register indexes
  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_SETLEN  = 1'b1;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [23:0] TIMEOUT_RESET = 24'd10000;
  localparam logic [8:0]  SETLEN_RESET  = 9'd64;

  typedef struct packed {
    logic [23:0] timeout_ticks;
    logic [8:0]  settings_length;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [4:0]  command_code;
    logic [7:0]  payload_byte;
    logic [15:0] word_value;
    logic [15:0] computed_crc;
    logic        crc_ok;
  } result_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [4:0] mode_code(input logic [1:0] mode);
    logic [4:0] code;
    case (mode)
      MODE_SET: code = CMD_NEW_SETTINGS;
      MODE_AIR: code = CMD_MFC_AIR_SET;
      default:  code = CMD_MFC_O2_SET;
    endcase
    return code;
  endfunction

endpackage

>>> sv/mcf_if.sv
// ----------------------------------------------------------------------------
// mcf_if
// Valid/ready channels for input beats and result beats.
// ----------------------------------------------------------------------------
interface mcf_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] rx_byte;

  modport source (output valid, output operation, output rx_byte, input ready);
  modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

interface mcf_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [4:0]  command_code;
  logic [7:0]  payload_byte;
  logic [15:0] word_value;
  logic [15:0] computed_crc;
  logic        crc_ok;

  modport source (output valid, output event_res, output command_code,
                  output payload_byte, output word_value, output computed_crc,
                  output crc_ok, input ready);
  modport sink   (input valid, input event_res, input command_code,
                  input payload_byte, input word_value, input computed_crc,
                  input crc_ok, output ready);
endinterface

>>> sv/mcf_matcher.sv
// ----------------------------------------------------------------------------
// mcf_matcher
// Compares the 32-bit byte window against the magic command words.
// ----------------------------------------------------------------------------
module mcf_matcher (
  input  logic [31:0] window,
  output logic        hit,
  output logic [4:0]  index
);

  always_comb begin
    hit   = 1'b0;
    index = '0;
    for (int i = 0; i < mcf_pkg::NUM_WORDS; i++) begin
      if (window == mcf_pkg::MAGIC_WORDS[i]) begin
        hit   = 1'b1;
        index = 5'(i);
      end
    end
  end

endmodule

>>> sv/mcf_engine.sv
// ----------------------------------------------------------------------------
// mcf_engine
// Framer state and per-beat next-state / result logic.
// ----------------------------------------------------------------------------
module mcf_engine #(
  parameter int MAX_FRAME_BYTES = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  logic             operation,
  input  logic [7:0]       rx_byte,
  input  mcf_pkg::cfg_t    cfg,
  output logic             res_valid,
  output mcf_pkg::result_t res
);

  localparam int CntW = $clog2(MAX_FRAME_BYTES + 1);
  localparam int LenW = (CntW > 9) ? CntW + 1 : 10;

  logic [31:0]     window_r, window_nxt;
  logic [2:0]      fill_r, fill_nxt;
  logic [1:0]      mode_r, mode_nxt;
  logic [CntW-1:0] pos_r, pos_nxt;
  logic [15:0]     crc_r, crc_nxt;
  logic [15:0]     acc_r, acc_nxt;
  logic [23:0]     ticks_r, ticks_nxt;

  logic [31:0]     win_shift;
  logic [2:0]      fill_inc;
  logic            hit;
  logic [4:0]      hit_idx;
  logic [LenW-1:0] len_raw, frame_len, pos_x;
  logic [23:0]     ticks_dec;
  logic [15:0]     rx_word, crc_final;

  assign win_shift = {rx_byte, window_r[31:8]};
  assign fill_inc  = (fill_r < 3'd4) ? fill_r + 3'd1 : fill_r;
  assign len_raw   = LenW'(cfg.settings_length);
  assign frame_len = (len_raw < LenW'(3)) ? LenW'(3) :
                     (len_raw > LenW'(MAX_FRAME_BYTES)) ? LenW'(MAX_FRAME_BYTES) : len_raw;
  assign pos_x     = LenW'(pos_r);
  assign ticks_dec = (ticks_r != 24'd0) ? ticks_r - 24'd1 : ticks_r;
  assign rx_word   = {rx_byte, acc_r[7:0]};
  assign crc_final = ~crc_r;

  mcf_matcher u_matcher (
    .window (win_shift),
    .hit    (hit),
    .index  (hit_idx)
  );

  always_comb begin
    window_nxt = window_r;
    fill_nxt   = fill_r;
    mode_nxt   = mode_r;
    pos_nxt    = pos_r;
    crc_nxt    = crc_r;
    acc_nxt    = acc_r;
    ticks_nxt  = ticks_r;
    res_valid  = 1'b0;
    res        = '0;
    if (fire) begin
      if (operation == mcf_pkg::OP_TICK) begin
        if (mode_r != mcf_pkg::MODE_IDLE) begin
          ticks_nxt = ticks_dec;
          if (ticks_dec == 24'd0) begin
            res_valid        = 1'b1;
            res.event_res    = mcf_pkg::EV_TIMEOUT;
            res.command_code = mcf_pkg::mode_code(mode_r);
            mode_nxt   = mcf_pkg::MODE_IDLE;
            pos_nxt    = '0;
            crc_nxt    = mcf_pkg::CRC_INIT;
            acc_nxt    = '0;
            window_nxt = '0;
            fill_nxt   = '0;
          end
        end
      end else begin
        unique case (mode_r)
          mcf_pkg::MODE_SET: begin
            if (pos_x + LenW'(2) < frame_len) begin
              crc_nxt = mcf_pkg::crc16_byte(crc_r, rx_byte);
            end else if (pos_x + LenW'(2) == frame_len) begin
              acc_nxt = {8'h00, rx_byte};
            end
            res_valid        = 1'b1;
            res.command_code = mcf_pkg::CMD_NEW_SETTINGS;
            res.payload_byte = rx_byte;
            if (pos_x + LenW'(1) >= frame_len) begin
              res.event_res    = mcf_pkg::EV_SETTINGS;
              res.word_value   = rx_word;
              res.computed_crc = crc_final;
              res.crc_ok       = (crc_final == rx_word);
              mode_nxt  = mcf_pkg::MODE_IDLE;
              pos_nxt   = '0;
              crc_nxt   = mcf_pkg::CRC_INIT;
              acc_nxt   = '0;
              ticks_nxt = '0;
            end else begin
              res.event_res = mcf_pkg::EV_PAYLOAD;
              pos_nxt       = pos_r + CntW'(1);
            end
          end
          mcf_pkg::MODE_AIR, mcf_pkg::MODE_O2: begin
            res_valid        = 1'b1;
            res.command_code = mcf_pkg::mode_code(mode_r);
            res.payload_byte = rx_byte;
            if (pos_r == '0) begin
              res.event_res = mcf_pkg::EV_PAYLOAD;
              acc_nxt       = {8'h00, rx_byte};
              pos_nxt       = CntW'(1);
            end else begin
              res.event_res  = mcf_pkg::EV_MFC;
              res.word_value = rx_word;
              mode_nxt  = mcf_pkg::MODE_IDLE;
              pos_nxt   = '0;
              crc_nxt   = mcf_pkg::CRC_INIT;
              acc_nxt   = '0;
              ticks_nxt = '0;
            end
          end
          default: begin
            window_nxt = win_shift;
            fill_nxt   = fill_inc;
            if (fill_inc == 3'd4 && hit) begin
              window_nxt       = '0;
              fill_nxt         = '0;
              res_valid        = 1'b1;
              res.event_res    = mcf_pkg::EV_CMD;
              res.command_code = hit_idx;
              if (hit_idx == mcf_pkg::CMD_NEW_SETTINGS || hit_idx == mcf_pkg::CMD_MFC_AIR_SET ||
                  hit_idx == mcf_pkg::CMD_MFC_O2_SET) begin
                mode_nxt  = (hit_idx == mcf_pkg::CMD_NEW_SETTINGS) ? mcf_pkg::MODE_SET :
                            (hit_idx == mcf_pkg::CMD_MFC_AIR_SET) ? mcf_pkg::MODE_AIR :
                            mcf_pkg::MODE_O2;
                pos_nxt   = '0;
                crc_nxt   = mcf_pkg::CRC_INIT;
                acc_nxt   = '0;
                ticks_nxt = (cfg.timeout_ticks == 24'd0) ? 24'd1 : cfg.timeout_ticks;
              end
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
      fill_r   <= '0;
      mode_r   <= mcf_pkg::MODE_IDLE;
      pos_r    <= '0;
      crc_r    <= mcf_pkg::CRC_INIT;
      acc_r    <= '0;
      ticks_r  <= '0;
    end else begin
      window_r <= window_nxt;
      fill_r   <= fill_nxt;
      mode_r   <= mode_nxt;
      pos_r    <= pos_nxt;
      crc_r    <= crc_nxt;
      acc_r    <= acc_nxt;
      ticks_r  <= ticks_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == mcf_pkg::MODE_IDLE) |-> (ticks_r == 24'd0 && pos_r == '0))
    else $error("idle framer holds collection state");

  a_collect_window_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r != mcf_pkg::MODE_IDLE) |-> (window_r == 32'd0 && fill_r == 3'd0))
    else $error("window not clear during collection");

  a_collect_ticks: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r != mcf_pkg::MODE_IDLE) |-> (ticks_r != 24'd0))
    else $error("collecting with expired timeout");
`endif

endmodule

>>> sv/magic_word_command_framer_top.sv
// ----------------------------------------------------------------------------
// magic_word_command_framer_top
// Magic word command framer: byte window matcher, settings frame CRC check,
// MFC value collection and tick timeout, with a registered result beat.
// ----------------------------------------------------------------------------
// Channel | Dir | Handshake     | Payload
// in_bus  | in  | valid/ready   | operation, rx_byte
// out_bus | out | valid/ready   | event_res, command_code, payload_byte,
//         |     |               | word_value, computed_crc, crc_ok
// cfg_*   | in  | write enable  | cfg_idx, cfg_data
//
// One beat per cycle while in_bus.ready is high; a beat's result, if any,
// appears in the next cycle from the single output register after the window
// compare and byte-wide CRC step. in_bus.ready is low only while a result is
// held and out_bus.ready is low. Active-low sync reset spares only out_res_r.
// ----------------------------------------------------------------------------
module magic_word_command_framer_top #(
  parameter int MAX_FRAME_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  mcf_in_if.sink      in_bus,
  mcf_out_if.source   out_bus,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [23:0] cfg_data
);

  mcf_pkg::cfg_t    cfg_r;
  mcf_pkg::result_t eng_res;
  mcf_pkg::result_t out_res_r;
  logic             eng_valid;
  logic             out_valid_r;
  logic             in_fire;

  assign in_bus.ready = !out_valid_r || out_bus.ready;
  assign in_fire      = in_bus.valid && in_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout_ticks   <= mcf_pkg::TIMEOUT_RESET;
      cfg_r.settings_length <= mcf_pkg::SETLEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        mcf_pkg::CFG_TIMEOUT: cfg_r.timeout_ticks   <= cfg_data;
        mcf_pkg::CFG_SETLEN:  cfg_r.settings_length <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  mcf_engine #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (in_fire),
    .operation (in_bus.operation),
    .rx_byte   (in_bus.rx_byte),
    .cfg       (cfg_r),
    .res_valid (eng_valid),
    .res       (eng_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= eng_valid;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_res_r <= eng_res;
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.event_res    = out_res_r.event_res;
  assign out_bus.command_code = out_res_r.command_code;
  assign out_bus.payload_byte = out_res_r.payload_byte;
  assign out_bus.word_value   = out_res_r.word_value;
  assign out_bus.computed_crc = out_res_r.computed_crc;
  assign out_bus.crc_ok       = out_res_r.crc_ok;

`ifndef ASSERT_OFF
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_bus.ready) |-> !in_bus.ready)
    else $error("input taken while result stalled");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_bus.ready) |=> (out_valid_r && $stable(out_res_r)))
    else $error("stalled result changed");

  a_crc_ok_event: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.crc_ok) |-> (out_res_r.event_res == mcf_pkg::EV_SETTINGS))
    else $error("crc_ok outside settings frame event");

  a_cmd_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.event_res == mcf_pkg::EV_CMD) |->
    (out_res_r.payload_byte == 8'd0 && out_res_r.word_value == 16'd0))
    else $error("command event carries payload");
`endif

endmodule
